// ===== design/pagerank_power_iteration_assert.svh =====
// Assertion macros used by the checker file prpi_checker.sv.
`ifndef PAGERANK_POWER_ITERATION_ASSERT_SVH
`define PAGERANK_POWER_ITERATION_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define PRPI_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prpi: same-cycle check failed");

// Condition implies consequence in the next cycle.
`define PRPI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prpi: next-cycle check failed");

`endif

// ===== design/prpi_pkg.sv =====
// ----------------------------------------------------------------------------
// prpi_pkg
// Types and constants for the PageRank power iteration engine.
// ----------------------------------------------------------------------------
package prpi_pkg;

  localparam int SUM_W = 37;
  localparam int W_W   = 38;
  localparam int MUL_A = 17;
  localparam int MUL_W = MUL_A + W_W;
  localparam int DEG_W = 7;

  localparam logic [31:0] RANK_ONE = 32'h8000_0000;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_RUN   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_DAMPING    = 2'd1;
  localparam logic [1:0] REG_MAX_ITER   = 2'd2;
  localparam logic [1:0] REG_CONV_LIMIT = 2'd3;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DEG_W-1:0] divisor;
  } div_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_INIT_DIV,
    S_INIT_WR,
    S_SUM_RD,
    S_SUM_ACC,
    S_SUM_DIV,
    S_TELE_MUL,
    S_TELE_GO,
    S_TELE_DIV,
    S_DN_DIV,
    S_ROW,
    S_ROW_LAST,
    S_ROW_MUL,
    S_ROW_UPD,
    S_ITER_END,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_WAIT
  } state_t;

endpackage

// ===== design/pagerank_power_iteration.sv =====
// ----------------------------------------------------------------------------
// pagerank_power_iteration
// Link loader and power-iteration engine with a shared divider and multiplier.
// ----------------------------------------------------------------------------
//  channel  | handshake                     | moves
//  in_      | in_valid / in_stall           | cmd, source, target transaction
//  out_     | out_valid / out_stall         | one rank per node, N per run
//  apb      | psel penable pwrite pready    | register write / read
//
// A link load passes S_LD_RD and S_LD_WR; a clear acts from S_IDLE.
// Run time is set by the divider wait per out-degree quotient and the N*N
// link-map read loop.
// Each result passes S_OUT_RD, S_OUT_LD and S_OUT_WAIT plus any output stall; in_stall is high for the run.
// Synchronous active-low reset clears control and link-map row valid bits.
module pagerank_power_iteration #(
  parameter int MAX_NODES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_source_node,
  input  logic [5:0]  in_target_node,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_node_index,
  output logic [31:0] out_rank_value,
  output logic        out_converged,
  output logic [15:0] out_iterations_used,
  output logic        out_is_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import prpi_pkg::*;

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  state_t state_r, state_nxt;

  logic [6:0]  node_count_r;
  logic [15:0] damping_r, max_iter_r, conv_lim_r;

  logic [MAX_NODES-1:0] link_mem [MAX_NODES];
  logic [DEG_W-1:0]     deg_mem  [MAX_NODES];
  logic [31:0]          rank_mem [MAX_NODES];
  logic [31:0]          quot_mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_vld_r, row_vld_nxt;

  logic [MAX_NODES-1:0] lk_rd_r;
  logic [DEG_W-1:0]     dg_rd_r;
  logic                 vl_rd_r;
  logic [31:0]          rk_rd_r, q_rd_r;

  logic [AW-1:0]        lk_addr, rk_addr, q_addr;
  logic                 lk_we, rk_we, q_we;
  logic [MAX_NODES-1:0] lk_wdata;
  logic [DEG_W-1:0]     dg_wdata;
  logic [31:0]          rk_wdata, q_wdata;

  logic [5:0]       src_r, src_nxt, dst_r, dst_nxt;
  logic [CW-1:0]    j_r, j_nxt, i_r, i_nxt;
  logic             pend_r, pend_nxt;
  logic [SUM_W-1:0] tot_r, tot_nxt, dng_r, dng_nxt, tele_r, tele_nxt, dn_r, dn_nxt;
  logic [W_W-1:0]   w_r, w_nxt;
  logic [MUL_W-1:0] mul_r, mul_nxt;
  logic             settled_r, settled_nxt, conv_r, conv_nxt;
  logic [15:0]      iter_r, iter_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [5:0]  out_idx_r, out_idx_nxt;
  logic [31:0] out_rank_r, out_rank_nxt;
  logic        out_last_r, out_last_nxt;

  logic [CW-1:0]        n_w;
  logic                 j_last, i_last, in_acc, cfg_wr;
  logic [MAX_NODES-1:0] row_eff;
  logic [DEG_W-1:0]     deg_eff;
  logic [MUL_A-1:0]     mul_a;
  logic [W_W-1:0]       mul_b;
  logic [39:0]          vsum;
  logic [31:0]          v32, vdiff;
  logic [15:0]          iter_inc;
  div_req_t             div_req;
  logic                 div_done;
  logic [SUM_W-1:0]     div_q;

  prpi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    if (node_count_r < 7'd2) begin
      n_w = CW'(2);
    end else if (node_count_r > 7'(MAX_NODES)) begin
      n_w = CW'(MAX_NODES);
    end else begin
      n_w = node_count_r[CW-1:0];
    end
  end

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign j_last   = (j_r == n_w - CW'(1));
  assign i_last   = (i_r == n_w - CW'(1));
  assign row_eff  = vl_rd_r ? lk_rd_r : '0;
  assign deg_eff  = vl_rd_r ? dg_rd_r : '0;
  assign iter_inc = iter_r + 16'd1;

  assign vsum  = {1'b0, mul_r[MUL_W-1:16]} + 40'(tele_r);
  assign v32   = (vsum > 40'(RANK_ONE)) ? RANK_ONE : vsum[31:0];
  assign vdiff = (v32 >= rk_rd_r) ? (v32 - rk_rd_r) : (rk_rd_r - v32);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_ADD: begin
              if (({1'b0, in_source_node} < 7'(n_w)) && ({1'b0, in_target_node} < 7'(n_w)))
                state_nxt = S_LD_RD;
            end
            CMD_RUN: state_nxt = S_INIT_DIV;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_RD:    state_nxt = S_LD_WR;
      S_LD_WR:    state_nxt = S_IDLE;
      S_INIT_DIV: if (div_done) state_nxt = S_INIT_WR;
      S_INIT_WR: begin
        if (j_last) state_nxt = (max_iter_r == 16'd0) ? S_OUT_RD : S_SUM_RD;
      end
      S_SUM_RD: state_nxt = S_SUM_ACC;
      S_SUM_ACC: begin
        if (deg_eff != '0) state_nxt = S_SUM_DIV;
        else state_nxt = j_last ? S_TELE_MUL : S_SUM_RD;
      end
      S_SUM_DIV:  if (div_done) state_nxt = j_last ? S_TELE_MUL : S_SUM_RD;
      S_TELE_MUL: state_nxt = S_TELE_GO;
      S_TELE_GO:  state_nxt = S_TELE_DIV;
      S_TELE_DIV: if (div_done) state_nxt = S_DN_DIV;
      S_DN_DIV:   if (div_done) state_nxt = S_ROW;
      S_ROW:      if (j_last) state_nxt = S_ROW_LAST;
      S_ROW_LAST: state_nxt = S_ROW_MUL;
      S_ROW_MUL:  state_nxt = S_ROW_UPD;
      S_ROW_UPD:  state_nxt = i_last ? S_ITER_END : S_ROW;
      S_ITER_END: begin
        state_nxt = (settled_r || (iter_inc >= max_iter_r)) ? S_OUT_RD : S_SUM_RD;
      end
      S_OUT_RD:   state_nxt = S_OUT_LD;
      S_OUT_LD:   state_nxt = S_OUT_WAIT;
      S_OUT_WAIT: begin
        if (!out_stall) state_nxt = out_last_r ? S_IDLE : S_OUT_RD;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    src_nxt       = src_r;
    dst_nxt       = dst_r;
    j_nxt         = j_r;
    i_nxt         = i_r;
    pend_nxt      = pend_r;
    tot_nxt       = tot_r;
    dng_nxt       = dng_r;
    tele_nxt      = tele_r;
    dn_nxt        = dn_r;
    w_nxt         = w_r;
    mul_nxt       = mul_r;
    settled_nxt   = settled_r;
    conv_nxt      = conv_r;
    iter_nxt      = iter_r;
    row_vld_nxt   = row_vld_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_rank_nxt  = out_rank_r;
    out_last_nxt  = out_last_r;
    lk_we         = 1'b0;
    rk_we         = 1'b0;
    q_we          = 1'b0;
    lk_wdata      = row_eff | (MAX_NODES'(1) << dst_r[AW-1:0]);
    dg_wdata      = deg_eff + DEG_W'(1);
    rk_wdata      = v32;
    q_wdata       = div_q[31:0];
    mul_a         = MUL_A'(17'd65536 - {1'b0, damping_r});
    mul_b         = w_r;
    div_req       = '{start: 1'b0, dividend: SUM_W'(RANK_ONE), divisor: 7'(n_w)};

    case (state_r)
      S_LD_RD, S_LD_WR: lk_addr = src_r[AW-1:0];
      default:          lk_addr = j_r[AW-1:0];
    endcase
    case (state_r)
      S_INIT_WR, S_SUM_RD, S_SUM_ACC, S_SUM_DIV: rk_addr = j_r[AW-1:0];
      default:                                   rk_addr = i_r[AW-1:0];
    endcase
    q_addr = j_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        src_nxt = in_source_node;
        dst_nxt = in_target_node;
        if (in_acc) begin
          case (in_cmd)
            CMD_CLEAR: row_vld_nxt = '0;
            CMD_RUN: begin
              div_req.start = 1'b1;
              iter_nxt      = 16'd0;
              conv_nxt      = 1'b0;
              j_nxt         = '0;
              i_nxt         = '0;
            end
            default: ;
          endcase
        end
      end
      S_LD_WR: begin
        if (!row_eff[dst_r[AW-1:0]]) begin
          lk_we                          = 1'b1;
          row_vld_nxt[src_r[AW-1:0]]     = 1'b1;
        end
      end
      S_INIT_WR: begin
        rk_we    = 1'b1;
        rk_wdata = div_q[31:0];
        j_nxt    = j_r + CW'(1);
        if (j_last) begin
          j_nxt       = '0;
          tot_nxt     = '0;
          dng_nxt     = '0;
          settled_nxt = 1'b1;
        end
      end
      S_SUM_ACC: begin
        tot_nxt = tot_r + SUM_W'(rk_rd_r);
        if (deg_eff == '0) begin
          dng_nxt = dng_r + SUM_W'(rk_rd_r);
          q_we    = 1'b1;
          q_wdata = '0;
          j_nxt   = j_last ? j_r : j_r + CW'(1);
        end else begin
          div_req = '{start: 1'b1, dividend: SUM_W'(rk_rd_r), divisor: deg_eff};
        end
      end
      S_SUM_DIV: begin
        if (div_done) begin
          q_we  = 1'b1;
          j_nxt = j_last ? j_r : j_r + CW'(1);
        end
      end
      S_TELE_MUL: begin
        mul_a   = {1'b0, damping_r};
        mul_b   = W_W'(tot_r);
        mul_nxt = MUL_W'(mul_a) * MUL_W'(mul_b);
      end
      S_TELE_GO: begin
        div_req = '{start: 1'b1, dividend: mul_r[SUM_W+15:16], divisor: 7'(n_w)};
      end
      S_TELE_DIV: begin
        if (div_done) begin
          tele_nxt = div_q;
          div_req  = '{start: 1'b1, dividend: dng_r, divisor: 7'(n_w)};
        end
      end
      S_DN_DIV: begin
        if (div_done) begin
          dn_nxt   = div_q;
          w_nxt    = W_W'(div_q);
          i_nxt    = '0;
          j_nxt    = '0;
          pend_nxt = 1'b0;
        end
      end
      S_ROW, S_ROW_LAST: begin
        if (pend_r && row_eff[i_r[AW-1:0]] && (deg_eff != '0))
          w_nxt = w_r + W_W'(q_rd_r);
        pend_nxt = (state_r == S_ROW);
        if (state_r == S_ROW && !j_last) j_nxt = j_r + CW'(1);
      end
      S_ROW_MUL: begin
        mul_nxt = MUL_W'(mul_a) * MUL_W'(mul_b);
      end
      S_ROW_UPD: begin
        rk_we = 1'b1;
        if (vdiff >= {16'd0, conv_lim_r}) settled_nxt = 1'b0;
        i_nxt    = i_last ? i_r : i_r + CW'(1);
        j_nxt    = '0;
        pend_nxt = 1'b0;
        w_nxt    = W_W'(dn_r);
      end
      S_ITER_END: begin
        iter_nxt    = iter_inc;
        conv_nxt    = settled_r;
        i_nxt       = '0;
        j_nxt       = '0;
        tot_nxt     = '0;
        dng_nxt     = '0;
        settled_nxt = 1'b1;
      end
      S_OUT_LD: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = 6'(i_r);
        out_rank_nxt  = rk_rd_r;
        out_last_nxt  = i_last;
      end
      S_OUT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          i_nxt         = i_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      link_mem[lk_addr] <= lk_wdata;
      deg_mem[lk_addr]  <= dg_wdata;
    end
    lk_rd_r <= link_mem[lk_addr];
    dg_rd_r <= deg_mem[lk_addr];
    vl_rd_r <= row_vld_r[lk_addr];
  end

  always_ff @(posedge clk) begin
    if (rk_we) rank_mem[rk_addr] <= rk_wdata;
    rk_rd_r <= rank_mem[rk_addr];
  end

  always_ff @(posedge clk) begin
    if (q_we) quot_mem[q_addr] <= q_wdata;
    q_rd_r <= quot_mem[q_addr];
  end

  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= 7'd4;
      damping_r    <= 16'd9830;
      max_iter_r   <= 16'd100;
      conv_lim_r   <= 16'd1933;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_NODE_COUNT: node_count_r <= pwdata[6:0];
        REG_DAMPING:    damping_r    <= pwdata[15:0];
        REG_MAX_ITER:   max_iter_r   <= pwdata[15:0];
        REG_CONV_LIMIT: conv_lim_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NODE_COUNT: prdata = {25'd0, node_count_r};
      REG_DAMPING:    prdata = {16'd0, damping_r};
      REG_MAX_ITER:   prdata = {16'd0, max_iter_r};
      REG_CONV_LIMIT: prdata = {16'd0, conv_lim_r};
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      iter_r      <= 16'd0;
      conv_r      <= 1'b0;
      settled_r   <= 1'b1;
      pend_r      <= 1'b0;
      j_r         <= '0;
      i_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
      iter_r      <= iter_nxt;
      conv_r      <= conv_nxt;
      settled_r   <= settled_nxt;
      pend_r      <= pend_nxt;
      j_r         <= j_nxt;
      i_r         <= i_nxt;
    end
    src_r      <= src_nxt;
    dst_r      <= dst_nxt;
    tot_r      <= tot_nxt;
    dng_r      <= dng_nxt;
    tele_r     <= tele_nxt;
    dn_r       <= dn_nxt;
    w_r        <= w_nxt;
    mul_r      <= mul_nxt;
    out_idx_r  <= out_idx_nxt;
    out_rank_r <= out_rank_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_node_index      = out_idx_r;
  assign out_rank_value      = out_rank_r;
  assign out_converged       = conv_r;
  assign out_iterations_used = iter_r;
  assign out_is_last         = out_last_r;

endmodule

// ===== design/prpi_div.sv =====
// ----------------------------------------------------------------------------
// prpi_div
// Restoring divider, one quotient bit per cycle, small divisor.
// ----------------------------------------------------------------------------
module prpi_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  prpi_pkg::div_req_t       req,
  output logic                     done,
  output logic [prpi_pkg::SUM_W-1:0] quotient
);
  import prpi_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] q_r, q_nxt;
  logic [DEG_W-1:0] rem_r, rem_nxt;
  logic [DEG_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEG_W:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[SUM_W-1]};
    if (req.start) begin
      q_nxt    = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = CNT_W'(SUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DEG_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEG_W-1:0];
        q_nxt   = {q_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== design/prpi_checker.sv =====
// ----------------------------------------------------------------------------
// prpi_checker
// Port-level checks for the PageRank engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "pagerank_power_iteration_assert.svh"

module prpi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_cmd,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_node_index,
  input logic [31:0] out_rank_value,
  input logic        out_converged,
  input logic [15:0] out_iterations_used,
  input logic        out_is_last
);
  import prpi_pkg::*;

  `PRPI_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_rank_value) && $stable(out_node_index))
  `PRPI_ASSERT_NOW(a_busy_while_out, out_valid, in_stall)
  `PRPI_ASSERT_NEXT(a_run_busy, in_valid && !in_stall && (in_cmd == CMD_RUN), in_stall)
  `PRPI_ASSERT_NOW(a_conv_iters, out_valid && out_converged, out_iterations_used != 16'd0)
  `PRPI_ASSERT_NEXT(a_out_gap, out_valid && !out_stall && !out_is_last, !out_valid)

endmodule

bind pagerank_power_iteration prpi_checker u_prpi_checker (.*);

// ===== bench/pagerank_power_iteration_check.sv =====
// ----------------------------------------------------------------------------
// pagerank_power_iteration_check
// Watches the register port and both channels of the PageRank engine, keeps
// its own copy of the link map, out-degrees and registers, computes the ranks
// of every run and compares each result transaction with the oldest one due.
// ----------------------------------------------------------------------------
module pagerank_power_iteration_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_source_node,
  input  logic [5:0]  in_target_node,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_node_index,
  input  logic [31:0] out_rank_value,
  input  logic        out_converged,
  input  logic [15:0] out_iterations_used,
  input  logic        out_is_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          ranks_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import prpi_pkg::*;

  typedef struct packed {
    logic [5:0]  node;
    logic [31:0] rank;
    logic        conv;
    logic [15:0] iters;
    logic        last;
  } rank_rec_t;

  rank_rec_t   rank_q[$];
  logic [6:0]  node_count;
  logic [15:0] damping;
  logic [15:0] iter_limit;
  logic [15:0] conv_bound;
  logic [63:0] links [64];
  logic [6:0]  degree [64];
  logic [31:0] rank_now [64];
  logic [31:0] rank_nxt [64];

  function automatic int unsigned nodes_used();
    if (node_count < 2) return 2;
    if (node_count > 64) return 64;
    return node_count;
  endfunction

  function automatic void predict_ranks();
    int unsigned n;
    int unsigned iters;
    bit          conv;
    bit          settled;
    logic [63:0] total, dangl, tele, w, v, diff;
    rank_rec_t   r;
    n = nodes_used();
    for (int i = 0; i < n; i++) rank_now[i] = RANK_ONE / n;
    iters = 0;
    conv = 0;
    while (!conv && iters < iter_limit) begin
      total = 0;
      dangl = 0;
      for (int j = 0; j < n; j++) begin
        total += rank_now[j];
        if (degree[j] == 0) dangl += rank_now[j];
      end
      tele = (64'(damping) * total) / (64'(n) << 16);
      settled = 1;
      for (int i = 0; i < n; i++) begin
        w = dangl / n;
        for (int j = 0; j < n; j++)
          if (degree[j] != 0 && links[j][i]) w += 64'(rank_now[j]) / 64'(degree[j]);
        v = tele + (((64'd65536 - 64'(damping)) * w) >> 16);
        if (v > 64'(RANK_ONE)) v = 64'(RANK_ONE);
        rank_nxt[i] = v[31:0];
        diff = (v >= 64'(rank_now[i])) ? v - rank_now[i] : 64'(rank_now[i]) - v;
        if (diff >= 64'(conv_bound)) settled = 0;
      end
      for (int i = 0; i < n; i++) rank_now[i] = rank_nxt[i];
      conv = settled;
      iters++;
    end
    for (int i = 0; i < n; i++) begin
      r.node  = 6'(i);
      r.rank  = rank_now[i];
      r.conv  = conv;
      r.iters = 16'(iters);
      r.last  = (i + 1 == n);
      rank_q.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    rank_rec_t   exp_r;
    int unsigned n;
    if (!rst_n) begin
      node_count <= 7'd4;
      damping    <= 16'd9830;
      iter_limit <= 16'd100;
      conv_bound <= 16'd1933;
      for (int i = 0; i < 64; i++) begin
        links[i]  = '0;
        degree[i] = '0;
      end
      rank_q.delete();
      fail_count <= 0;
      ranks_due  <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_NODE_COUNT: node_count <= pwdata[6:0];
          REG_DAMPING:    damping    <= pwdata[15:0];
          REG_MAX_ITER:   iter_limit <= pwdata[15:0];
          REG_CONV_LIMIT: conv_bound <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        n = nodes_used();
        case (in_cmd)
          CMD_ADD: begin
            if (in_source_node < n && in_target_node < n
                && !links[in_source_node][in_target_node]) begin
              links[in_source_node][in_target_node] = 1'b1;
              degree[in_source_node] = degree[in_source_node] + 7'd1;
            end
          end
          CMD_CLEAR: begin
            for (int i = 0; i < 64; i++) begin
              links[i]  = '0;
              degree[i] = '0;
            end
          end
          CMD_RUN: predict_ranks();
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (rank_q.size() == 0) begin
          $error("unexpected result transaction, node %0d", out_node_index);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = rank_q.pop_front();
          if (out_node_index !== exp_r.node ||
              out_rank_value !== exp_r.rank ||
              out_converged !== exp_r.conv ||
              out_iterations_used !== exp_r.iters ||
              out_is_last !== exp_r.last)
            fail_count <= fail_count + 1;
          if (out_node_index !== exp_r.node)
            $error("node_index: expected %0d, got %0d", exp_r.node, out_node_index);
          if (out_rank_value !== exp_r.rank)
            $error("rank_value: expected %h, got %h", exp_r.rank, out_rank_value);
          if (out_converged !== exp_r.conv)
            $error("converged: expected %0d, got %0d", exp_r.conv, out_converged);
          if (out_iterations_used !== exp_r.iters)
            $error("iterations_used: expected %0d, got %0d", exp_r.iters,
                   out_iterations_used);
          if (out_is_last !== exp_r.last)
            $error("is_last: expected %0d, got %0d", exp_r.last, out_is_last);
        end
      end
      ranks_due <= rank_q.size();
    end
  end
endmodule

// ===== bench/pagerank_power_iteration_test.sv =====
// ----------------------------------------------------------------------------
// pagerank_power_iteration_test
// Drives link loads, clears and runs into the PageRank engine under several
// register settings with random gaps and output stalls, one long output
// hold-off included; the checker predicts and compares every rank.
// ----------------------------------------------------------------------------
module pagerank_power_iteration_test;
  timeunit 1ns;
  timeprecision 1ps;
  import prpi_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  in_cmd = CMD_ADD;
  logic [5:0]  in_source_node = 0;
  logic [5:0]  in_target_node = 0;
  logic        out_valid;
  logic        out_stall = 1;
  logic [5:0]  out_node_index;
  logic [31:0] out_rank_value;
  logic        out_converged;
  logic [15:0] out_iterations_used;
  logic        out_is_last;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          ranks_due;
  bit          quiet = 0;
  bit          long_hold = 0;
  int unsigned cur_nodes = 4;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  pagerank_power_iteration dut (.*);
  pagerank_power_iteration_check chk (.*);

  initial begin
    #(12 * 4_000_000);
    $display("simulation failed");
    $finish;
  end

  // result side
  initial begin
    int unsigned w;
    repeat (6) @(negedge clk);
    forever begin
      w = quiet ? 0 : $urandom_range(0, 13);
      if (long_hold) begin
        w = 500;
        long_hold = 0;
      end
      if (w > 0) begin
        out_stall <= 1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
  endtask

  task automatic set_regs(input logic [6:0] n, input logic [15:0] d,
                          input logic [15:0] it, input logic [15:0] lim);
    in_valid <= 0;
    wait (ranks_due == 0);
    repeat (20) @(negedge clk);
    reg_write(REG_NODE_COUNT, 32'(n));
    reg_write(REG_DAMPING, 32'(d));
    reg_write(REG_MAX_ITER, 32'(it));
    reg_write(REG_CONV_LIMIT, 32'(lim));
    psel <= 0; penable <= 0; pwrite <= 0;
    cur_nodes = (n < 2) ? 2 : (n > 64) ? 64 : n;
  endtask

  task automatic send(input logic [1:0] c, input logic [5:0] s, input logic [5:0] t);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_cmd <= c; in_source_node <= s; in_target_node <= t; in_valid <= 1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic random_items(input int count, input int run_odds, input bit wide);
    int unsigned r;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < run_odds) send(CMD_RUN, 6'($urandom), 6'($urandom));
      else if (r < run_odds + 3) send(CMD_CLEAR, 6'($urandom), 6'($urandom));
      else if (r < run_odds + 5) send(2'd3, 6'($urandom), 6'($urandom));
      else if (wide || r > 92) send(CMD_ADD, 6'($urandom), 6'($urandom));
      else send(CMD_ADD, 6'($urandom_range(0, cur_nodes - 1)),
                6'($urandom_range(0, cur_nodes - 1)));
    end
    send(CMD_RUN, 0, 0);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // defaults: four nodes
    send(CMD_RUN, 0, 0);
    send(CMD_ADD, 0, 1);
    send(CMD_ADD, 1, 2);
    send(CMD_ADD, 2, 0);
    send(CMD_ADD, 3, 0);
    send(CMD_ADD, 0, 1);
    send(CMD_ADD, 5, 1);
    send(CMD_ADD, 1, 63);
    send(CMD_ADD, 63, 63);
    send(CMD_ADD, 0, 0);
    send(2'd3, 63, 63);
    send(CMD_RUN, 63, 63);
    send(CMD_CLEAR, 0, 0);
    send(CMD_ADD, 0, 3);
    send(CMD_ADD, 2, 3);
    send(CMD_RUN, 0, 0);
    // node count below range, no iterations, zero bound
    set_regs(7'd1, 16'd65535, 16'd0, 16'd0);
    send(CMD_ADD, 0, 1);
    send(CMD_RUN, 0, 0);
    set_regs(7'd0, 16'd65535, 16'd5, 16'd0);
    send(CMD_RUN, 0, 0);
    // node count above range, full-width links
    set_regs(7'd127, 16'd1, 16'd1, 16'd65535);
    random_items(28, 0, 1);
    set_regs(7'd64, 16'd32768, 16'd2, 16'd0);
    send(CMD_RUN, 0, 0);
    // lowered node count with stored links beyond it
    set_regs(7'd5, 16'd9830, 16'd6, 16'd1933);
    long_hold = 1;
    random_items(14, 15, 0);
    for (int p = 0; p < 5; p++) begin
      quiet = (p == 2);
      set_regs(($urandom_range(0, 3) == 0) ? 7'($urandom_range(9, 16))
                                           : 7'($urandom_range(2, 8)),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 12)),
               ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 300))
                                           : 16'($urandom_range(0, 65535)));
      random_items(16, 14, 0);
    end
    quiet = 0;
    in_valid <= 0;
    wait (ranks_due == 0);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
